// ===== hw/rtl/core_stage_sparing_governor_macros.svh =====
// Assertion helpers used by the governor datapath.
`ifndef CORE_STAGE_SPARING_GOVERNOR_MACROS_SVH
`define CORE_STAGE_SPARING_GOVERNOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CSGOV_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("governor check failed");
// Next-cycle implication.
`define CSGOV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("governor check failed");
`else
`define CSGOV_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CSGOV_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/csgov_pkg.sv =====
package csgov_pkg;

    // Sizing of the governed system.
    localparam int NUM_CPUS    = 8;
    localparam int MAX_DOMAINS = 4;
    localparam int MAX_STAGES  = 8;

    localparam int DOM_W   = $clog2(MAX_DOMAINS);
    localparam int STG_W   = $clog2(MAX_STAGES);
    localparam int CPU_W   = $clog2(NUM_CPUS);
    localparam int CNT_W   = $clog2(MAX_STAGES + 1);
    localparam int ADDR_W  = DOM_W + STG_W;
    localparam int DEPTH   = MAX_DOMAINS * MAX_STAGES;
    localparam int SUM_W   = 14;
    localparam int PROD_W  = 26;

    localparam logic [9:0]  RATIO_MAX      = 10'd1023;
    localparam logic [10:0] UTIL_MAX       = 11'd2047;
    localparam logic [9:0]  PCT            = 10'd100;
    localparam logic [9:0]  DEFAULT_PERIOD = 10'd16;

    // Command codes.
    localparam logic [2:0] CMD_LOAD_DOMAIN  = 3'd0;
    localparam logic [2:0] CMD_LOAD_STAGE   = 3'd1;
    localparam logic [2:0] CMD_STAGE_RATIO  = 3'd2;
    localparam logic [2:0] CMD_DOMAIN_RATIO = 3'd3;
    localparam logic [2:0] CMD_UTIL         = 3'd4;
    localparam logic [2:0] CMD_TICK         = 3'd5;
    localparam logic [2:0] CMD_ENABLE       = 3'd6;
    localparam logic [2:0] CMD_BUSY         = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_UPDATE_PERIOD = 2'd0;
    localparam logic [1:0] REG_DOMAINS       = 2'd1;
    localparam logic [1:0] REG_FASTEST_MASK  = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  domain_index;
        logic [2:0]  stage_sel;
        logic [2:0]  cpu_index;
        logic [15:0] value;
        logic [7:0]  cpu_mask;
        logic [31:0] now_ms;
        logic [7:0]  online_mask;
        logic [7:0]  active_mask;
        logic [3:0]  misfit_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] governor_mask;
        logic       mask_changed;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] thr;
        logic [7:0]  cpus;
    } t_stage_entry;

    // Controller to datapath commands.
    typedef struct packed {
        logic             capture;
        logic             exec;
        logic             dom_start_tick;
        logic             dom_start_force;
        logic             sum_step;
        logic             rd_back;
        logic             mul;
        logic             step_up;
        logic             step_down;
        logic             mask_or;
        logic             finish;
        logic             tick_mode;
        logic             load_out;
        logic [DOM_W:0]   dom_cnt;
        logic [CPU_W-1:0] cpu;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic bad;
        logic is_tick;
        logic tick_ok;
        logic force_now;
        logic dom_done;
        logic dom_empty;
        logic set_empty;
        logic can_fwd;
        logic can_back;
        logic fwd_go;
        logic back_go;
        logic out_free;
    } t_dp_stat;

    // Lowest-numbered fast CPUs, one per misfit task.
    function automatic logic [7:0] misfit_mask(input logic [7:0] fast,
                                               input logic [3:0] count);
        logic [7:0] m;
        logic [3:0] left;
        m    = '0;
        left = count;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (fast[c] && left != 4'd0) begin
                m[c] = 1'b1;
                left = left - 4'd1;
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/csgov_ctrl.sv =====
module csgov_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csgov_pkg::t_dp_stat i_stat,
    output csgov_pkg::t_dp_cmd  o_cmd
);
    import csgov_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DOM      = 4'd2;
    localparam logic [3:0] S_SUM      = 4'd3;
    localparam logic [3:0] S_FWD_RD   = 4'd4;
    localparam logic [3:0] S_FWD_MUL  = 4'd5;
    localparam logic [3:0] S_FWD_CMP  = 4'd6;
    localparam logic [3:0] S_BACK_RD  = 4'd7;
    localparam logic [3:0] S_BACK_MUL = 4'd8;
    localparam logic [3:0] S_BACK_CMP = 4'd9;
    localparam logic [3:0] S_MASK_RD  = 4'd10;
    localparam logic [3:0] S_MASK_OR  = 4'd11;
    localparam logic [3:0] S_FINAL    = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]       r_state, n_state;
    logic [DOM_W:0]   r_dom, n_dom;
    logic [CPU_W-1:0] r_cpu, n_cpu;
    logic             r_tick, n_tick;

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dom   <= '0;
            r_cpu   <= '0;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dom   <= n_dom;
            r_cpu   <= n_cpu;
            r_tick  <= n_tick;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_dom   = r_dom;
        n_cpu   = r_cpu;
        n_tick  = r_tick;
        o_cmd           = '0;
        o_cmd.dom_cnt   = r_dom;
        o_cmd.cpu       = r_cpu;
        o_cmd.tick_mode = r_tick;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                n_dom = '0;
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else if (i_stat.is_tick && i_stat.tick_ok) begin
                    n_tick  = 1'b1;
                    n_state = S_DOM;
                end else if (i_stat.force_now) begin
                    n_tick  = 1'b0;
                    n_state = S_DOM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DOM: begin
                if (i_stat.dom_done) begin
                    n_state = S_FINAL;
                end else if (i_stat.dom_empty) begin
                    n_dom = r_dom + 1'b1;
                end else if (r_tick) begin
                    o_cmd.dom_start_tick = 1'b1;
                    n_cpu   = '0;
                    n_state = S_SUM;
                end else begin
                    o_cmd.dom_start_force = 1'b1;
                    n_state = S_MASK_RD;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_cpu = r_cpu + 1'b1;
                if (r_cpu == CPU_W'(NUM_CPUS - 1)) begin
                    n_state = i_stat.set_empty ? S_MASK_RD : S_FWD_RD;
                end
            end
            S_FWD_RD: begin
                n_state = i_stat.can_fwd ? S_FWD_MUL : S_BACK_RD;
            end
            S_FWD_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_FWD_CMP;
            end
            S_FWD_CMP: begin
                if (i_stat.fwd_go) begin
                    o_cmd.step_up = 1'b1;
                    n_state = S_FWD_RD;
                end else begin
                    n_state = S_BACK_RD;
                end
            end
            S_BACK_RD: begin
                o_cmd.rd_back = 1'b1;
                n_state = i_stat.can_back ? S_BACK_MUL : S_MASK_RD;
            end
            S_BACK_MUL: begin
                o_cmd.rd_back = 1'b1;
                o_cmd.mul = 1'b1;
                n_state = S_BACK_CMP;
            end
            S_BACK_CMP: begin
                if (i_stat.back_go) begin
                    o_cmd.step_down = 1'b1;
                    n_state = S_BACK_RD;
                end else begin
                    n_state = S_MASK_RD;
                end
            end
            S_MASK_RD: begin
                n_state = S_MASK_OR;
            end
            S_MASK_OR: begin
                o_cmd.mask_or = 1'b1;
                n_dom = r_dom + 1'b1;
                n_state = S_DOM;
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/csgov_dp.sv =====
`include "core_stage_sparing_governor_macros.svh"

module csgov_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csgov_pkg::t_dp_cmd   i_cmd,
    output csgov_pkg::t_dp_stat  o_stat,
    input  csgov_pkg::t_in_item  i_in_data,
    input  logic [9:0]           i_period,
    input  logic [2:0]           i_domains,
    input  logic [7:0]           i_fastest,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output csgov_pkg::t_out_item o_out_data
);
    import csgov_pkg::*;

    // Captured transaction and per-item bookkeeping.
    t_in_item    r_item;
    logic [7:0]  r_before;
    logic [1:0]  r_status;

    // Governor state.
    logic [7:0]        r_dom_cpus  [MAX_DOMAINS];
    logic [CNT_W-1:0]  r_dom_cnt   [MAX_DOMAINS];
    logic [STG_W-1:0]  r_dom_cur   [MAX_DOMAINS];
    logic [9:0]        r_dom_ratio [MAX_DOMAINS];
    logic [10:0]       r_util      [NUM_CPUS];
    logic [7:0]        r_ungov;
    logic [7:0]        r_allowed;
    logic [31:0]       r_last;
    logic              r_gov_on;
    logic              r_skip;

    // Stage tables.
    t_stage_entry      mem_sc   [DEPTH];
    logic [9:0]        mem_tune [DEPTH];
    logic [DEPTH-1:0]  r_tune_vld;
    t_stage_entry      r_sc_q;
    logic [9:0]        r_tune_q;
    logic              r_tune_vld_q;

    // Working registers for one domain walk.
    logic [STG_W-1:0]  r_cur;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_m;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [DOM_W-1:0]  w_dom;
    logic [7:0]        w_set;
    logic [2:0]        w_gov_n;
    logic              w_bad;
    logic [32:0]       w_due;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_sc_addr;
    logic [ADDR_W-1:0] w_tune_addr;
    logic [STG_W-1:0]  w_sc_stage;
    logic [9:0]        w_tune_eff;
    logic [9:0]        w_ratio;
    logic [15:0]       w_thr_eff;
    logic [PROD_W-1:0] w_sum100;
    logic [PROD_W-1:0] w_sum1_100;
    logic              w_cur_lt_cnt;
    logic [1:0]        w_status;
    logic              w_val_nz;

    assign w_dom    = i_cmd.dom_cnt[DOM_W-1:0];
    assign w_set    = r_item.online_mask & r_dom_cpus[w_dom];
    assign w_gov_n  = (i_domains > 3'(MAX_DOMAINS)) ? 3'(MAX_DOMAINS) : i_domains;
    assign w_val_nz = (r_item.value != 16'd0);

    // Index checks for the addressed command.
    always_comb begin
        w_bad = 1'b0;
        if (r_item.command <= CMD_DOMAIN_RATIO && int'(r_item.domain_index) >= MAX_DOMAINS) begin
            w_bad = 1'b1;
        end
        if ((r_item.command == CMD_LOAD_STAGE || r_item.command == CMD_STAGE_RATIO) &&
            int'(r_item.stage_sel) >= MAX_STAGES) begin
            w_bad = 1'b1;
        end
        if (r_item.command == CMD_UTIL && int'(r_item.cpu_index) >= NUM_CPUS) begin
            w_bad = 1'b1;
        end
    end

    assign w_due = {1'b0, r_last} + 33'(i_period);

    always_comb begin
        if (w_bad) begin
            w_status = STATUS_BAD_INDEX;
        end else if (r_item.command == CMD_TICK && !o_stat.tick_ok) begin
            w_status = STATUS_SKIPPED;
        end else begin
            w_status = STATUS_DONE;
        end
    end

    // Stage table addressing.
    assign w_wr_addr   = {r_item.domain_index[DOM_W-1:0], r_item.stage_sel[STG_W-1:0]};
    assign w_sc_stage  = i_cmd.rd_back ? (r_cur - 1'b1) : r_cur;
    assign w_sc_addr   = {w_dom, w_sc_stage};
    assign w_tune_addr = {w_dom, r_cur};

    // Threshold scaling operands and comparisons.
    assign w_tune_eff = r_tune_vld_q ? r_tune_q : 10'd0;
    assign w_ratio    = (w_tune_eff > r_dom_ratio[w_dom]) ? w_tune_eff : r_dom_ratio[w_dom];
    assign w_thr_eff  = i_cmd.rd_back ? (r_sc_q.thr >> 1) : r_sc_q.thr;
    assign w_sum100   = PROD_W'(r_sum) * PROD_W'(PCT);
    assign w_sum1_100 = PROD_W'(r_sum + 1'b1) * PROD_W'(PCT);
    assign w_cur_lt_cnt = (CNT_W'(r_cur) < r_dom_cnt[w_dom]);

    // Status toward the controller.
    always_comb begin
        o_stat.bad       = w_bad;
        o_stat.is_tick   = (r_item.command == CMD_TICK);
        o_stat.tick_ok   = r_gov_on && (i_domains != 3'd0) && !r_skip &&
                           ({1'b0, r_item.now_ms} >= w_due);
        o_stat.force_now = ((r_item.command == CMD_ENABLE) && r_gov_on && !w_val_nz) ||
                           ((r_item.command == CMD_BUSY) && r_gov_on && !r_skip && w_val_nz);
        o_stat.dom_done  = (i_cmd.dom_cnt >= w_gov_n);
        o_stat.dom_empty = (r_dom_cnt[w_dom] == '0);
        o_stat.set_empty = (w_set == 8'd0);
        o_stat.can_fwd   = ((CNT_W'(r_cur) + 1'b1) < r_dom_cnt[w_dom]);
        o_stat.can_back  = (r_cur != '0);
        o_stat.fwd_go    = (w_sum100 > r_prod);
        o_stat.back_go   = (w_sum1_100 <= r_prod);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Stage tables: written by the load-stage and stage-ratio commands, read once per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !w_bad && r_item.command == CMD_LOAD_STAGE) begin
            mem_sc[w_wr_addr] <= '{thr: r_item.value, cpus: r_item.cpu_mask};
        end
        if (i_cmd.exec && !w_bad && r_item.command == CMD_STAGE_RATIO) begin
            mem_tune[w_wr_addr] <= (r_item.value > 16'(RATIO_MAX)) ? RATIO_MAX
                                                                   : r_item.value[9:0];
        end
        r_sc_q       <= mem_sc[w_sc_addr];
        r_tune_q     <= mem_tune[w_tune_addr];
        r_tune_vld_q <= r_tune_vld[w_tune_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tune_vld <= '0;
        end else if (i_cmd.exec && !w_bad && r_item.command == CMD_STAGE_RATIO) begin
            r_tune_vld[w_wr_addr] <= 1'b1;
        end
    end

    // Captured item and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_in_data;
            r_before <= r_allowed;
            r_m      <= 8'd0;
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
        end
        if (i_cmd.dom_start_tick) begin
            r_cur <= (CNT_W'(r_dom_cur[w_dom]) >= r_dom_cnt[w_dom])
                     ? STG_W'(r_dom_cnt[w_dom] - 1'b1) : r_dom_cur[w_dom];
            r_sum <= '0;
        end else if (i_cmd.dom_start_force) begin
            r_cur <= STG_W'(r_dom_cnt[w_dom] - 1'b1);
        end else if (i_cmd.step_up) begin
            r_cur <= r_cur + 1'b1;
        end else if (i_cmd.step_down) begin
            r_cur <= r_cur - 1'b1;
        end
        if (i_cmd.sum_step && w_set[i_cmd.cpu]) begin
            r_sum <= r_sum + SUM_W'(r_util[i_cmd.cpu]);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(w_thr_eff) * PROD_W'(w_ratio);
        end
        if (i_cmd.mask_or) begin
            r_m <= r_m | r_sc_q.cpus;
        end
    end

    // Governor state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DOMAINS; d++) begin
                r_dom_cpus[d]  <= '0;
                r_dom_cnt[d]   <= '0;
                r_dom_cur[d]   <= '0;
                r_dom_ratio[d] <= PCT;
            end
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_util[c] <= '0;
            end
            r_ungov   <= 8'hFF;
            r_allowed <= 8'hFF;
            r_last    <= '0;
            r_gov_on  <= 1'b1;
            r_skip    <= 1'b0;
        end else begin
            if (i_cmd.exec && !w_bad) begin
                unique case (r_item.command)
                    CMD_LOAD_DOMAIN: begin
                        r_dom_cpus[r_item.domain_index]  <= r_item.cpu_mask;
                        r_dom_cnt[r_item.domain_index]   <=
                            (r_item.value > 16'(MAX_STAGES)) ? CNT_W'(MAX_STAGES)
                                                             : r_item.value[CNT_W-1:0];
                        r_dom_cur[r_item.domain_index]   <= '0;
                        r_dom_ratio[r_item.domain_index] <= PCT;
                        r_ungov <= r_ungov & ~r_item.cpu_mask;
                    end
                    CMD_DOMAIN_RATIO: begin
                        r_dom_ratio[r_item.domain_index] <=
                            (r_item.value > 16'(RATIO_MAX)) ? RATIO_MAX : r_item.value[9:0];
                    end
                    CMD_UTIL: begin
                        r_util[r_item.cpu_index] <=
                            (r_item.value > 16'(UTIL_MAX)) ? UTIL_MAX : r_item.value[10:0];
                    end
                    CMD_ENABLE: begin
                        r_gov_on <= w_val_nz;
                    end
                    CMD_BUSY: begin
                        r_skip <= w_val_nz;
                    end
                    CMD_LOAD_STAGE, CMD_STAGE_RATIO, CMD_TICK: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mask_or) begin
                r_dom_cur[w_dom] <= r_cur;
            end
            if (i_cmd.finish) begin
                r_allowed <= r_m | r_ungov |
                             (i_cmd.tick_mode ? misfit_mask(i_fastest & r_item.active_mask,
                                                            r_item.misfit_count) : 8'd0);
                if (i_cmd.tick_mode) begin
                    r_last <= r_item.now_ms;
                end
            end
        end
    end

    // Output register; a finished result waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.governor_mask <= r_allowed;
            r_out.mask_changed  <= (r_allowed != r_before);
            r_out.status        <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CSGOV_ASSERT_IMPL(a_step_up_in_range, i_clk, i_rst_n, i_cmd.step_up, o_stat.can_fwd)
    `CSGOV_ASSERT_IMPL(a_stage_kept_in_range, i_clk, i_rst_n, i_cmd.mask_or, w_cur_lt_cnt)
    `CSGOV_ASSERT_NEXT(a_tick_stamps_time, i_clk, i_rst_n, i_cmd.finish && i_cmd.tick_mode, r_last == $past(r_item.now_ms))

endmodule

// ===== hw/rtl/core_stage_sparing_governor.sv =====
// Non-tick commands without a forced update, and skipped ticks, go from decode straight to the output stage.
// Performed tick: per governed domain with stages, a one-CPU-per-cycle utilization sum, then
// threshold compares that step the stage up, then down, and a read of the stage's CPU mask;
// a forced update takes each domain with stages to its last stage and reads its CPU mask.
// The next item can be taken once the result has entered the output register.
// Reset is synchronous and active low; stage tables are not cleared and hold no value until loaded.
module core_stage_sparing_governor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  csgov_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output csgov_pkg::t_out_item o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import csgov_pkg::*;

    logic [9:0] r_period;
    logic [2:0] r_domains;
    logic [7:0] r_fastest;
    logic [1:0] w_reg_idx;
    logic       w_wr;

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= DEFAULT_PERIOD;
            r_domains <= '0;
            r_fastest <= '0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_UPDATE_PERIOD: r_period  <= pwdata[9:0];
                REG_DOMAINS:       r_domains <= pwdata[2:0];
                REG_FASTEST_MASK:  r_fastest <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (w_reg_idx)
            REG_UPDATE_PERIOD: prdata = 32'(r_period);
            REG_DOMAINS:       prdata = 32'(r_domains);
            REG_FASTEST_MASK:  prdata = 32'(r_fastest);
            default:           prdata = 32'd0;
        endcase
    end

    csgov_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csgov_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_period    (r_period),
        .i_domains   (r_domains),
        .i_fastest   (r_fastest),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
